// ===== hdl/umfc_pkg.sv =====
// Shared constants and types for the UDP multicast frame classifier.
`default_nettype none

package umfc_pkg;

  // Frame layout. The IPv4 header is taken to be 20 bytes long.
  localparam int unsigned PAYLOAD_OFFSET   = 42;
  localparam int unsigned OPERATION_OFFSET = 0;
  localparam int unsigned STATUS_OFFSET    = 1;
  localparam int unsigned MAX_FRAME_DEF    = 2048;

  localparam int unsigned IP_START  = 14;
  localparam int unsigned UDP_START = IP_START + 20;

  localparam int unsigned POS_LINK_HI   = 4;
  localparam int unsigned POS_LINK_LO   = 5;
  localparam int unsigned POS_ETYPE_HI  = 12;
  localparam int unsigned POS_ETYPE_LO  = 13;
  localparam int unsigned POS_IP_VER    = IP_START;
  localparam int unsigned POS_IP_PROTO  = IP_START + 9;
  localparam int unsigned POS_GROUP_HI  = IP_START + 16;
  localparam int unsigned POS_GROUP_LO  = IP_START + 17;
  localparam int unsigned POS_SPORT_HI  = UDP_START;
  localparam int unsigned POS_SPORT_LO  = UDP_START + 1;
  localparam int unsigned POS_DPORT_HI  = UDP_START + 2;
  localparam int unsigned POS_DPORT_LO  = UDP_START + 3;
  localparam int unsigned POS_ULEN_HI   = UDP_START + 4;
  localparam int unsigned POS_ULEN_LO   = UDP_START + 5;
  localparam int unsigned POS_OPERATION = PAYLOAD_OFFSET + OPERATION_OFFSET;
  localparam int unsigned POS_STATUS    = PAYLOAD_OFFSET + STATUS_OFFSET;

  // Widest frame length the parameter range allows.
  localparam int unsigned FRAME_LEN_W   = 12;
  localparam int unsigned MIN_FRAME_LEN = PAYLOAD_OFFSET + 7;

  localparam logic [7:0]  ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0]  ETYPE_IPV4_LO = 8'h00;
  localparam logic [3:0]  IP_VERSION4   = 4'd4;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [10:0] PAYLOAD_MAX   = 11'h7FF;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PORT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_PREFIX = 1'b1;
  localparam logic [15:0] MATCH_PORT_RST   = 16'd100;
  localparam logic [15:0] GROUP_PREFIX_RST = 16'd57568;

  // Frame state as it stands once the current byte is taken into account.
  typedef struct packed {
    logic                   hdr_ok;
    logic [15:0]            link;
    logic [15:0]            udp_len;
    logic [7:0]             operation;
    logic [7:0]             status;
    logic [FRAME_LEN_W-1:0] len;
  } frame_t;

endpackage

`default_nettype wire

// ===== hdl/umfc_frame_tracker.sv =====
// Byte counter, header checks and field capture for one frame at a time.
`default_nettype none

module umfc_frame_tracker
  import umfc_pkg::*;
#(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        last_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] match_port_i,
  input  wire logic [15:0] group_prefix_i,
  output frame_t           frame_o
);

  localparam int unsigned PosW = $clog2(MaxFrame + 1);

  logic [PosW-1:0] pos_q, pos_d, len_next;
  logic            hdr_ok_q, hdr_ok_d;
  logic [15:0]     link_q, link_d, link_next;
  logic [15:0]     ulen_q, ulen_d, ulen_next;
  logic [7:0]      op_q, op_d, op_next;
  logic [7:0]      stat_q, stat_d, stat_next;
  logic [31:0]     pos32;
  logic            take;
  logic            mismatch;
  logic            hdr_ok_next;

  assign pos32 = 32'(pos_q);
  assign take  = pos32 < 32'(MaxFrame);

  always_comb begin
    len_next  = take ? pos_q + PosW'(1) : pos_q;
    link_next = link_q;
    ulen_next = ulen_q;
    op_next   = op_q;
    stat_next = stat_q;
    mismatch  = 1'b0;
    if (take) begin
      case (pos32)
        POS_LINK_HI:  link_next[15:8] = byte_i;
        POS_LINK_LO:  link_next[7:0]  = byte_i;
        POS_ETYPE_HI: mismatch = byte_i != ETYPE_IPV4_HI;
        POS_ETYPE_LO: mismatch = byte_i != ETYPE_IPV4_LO;
        POS_IP_VER:   mismatch = byte_i[7:4] != IP_VERSION4;
        POS_IP_PROTO: mismatch = byte_i != IP_PROTO_UDP;
        POS_GROUP_HI: mismatch = byte_i != group_prefix_i[15:8];
        POS_GROUP_LO: mismatch = byte_i != group_prefix_i[7:0];
        POS_SPORT_HI: mismatch = byte_i != match_port_i[15:8];
        POS_SPORT_LO: mismatch = byte_i != match_port_i[7:0];
        POS_DPORT_HI: mismatch = byte_i != match_port_i[15:8];
        POS_DPORT_LO: mismatch = byte_i != match_port_i[7:0];
        POS_ULEN_HI:  ulen_next[15:8] = byte_i;
        POS_ULEN_LO:  ulen_next[7:0]  = byte_i;
        default: ;
      endcase
      if (pos32 == 32'(POS_OPERATION)) op_next = byte_i;
      if (pos32 == 32'(POS_STATUS))    stat_next = byte_i;
    end
    hdr_ok_next = hdr_ok_q & ~mismatch;
  end

  always_comb begin
    pos_d    = pos_q;
    hdr_ok_d = hdr_ok_q;
    link_d   = link_q;
    ulen_d   = ulen_q;
    op_d     = op_q;
    stat_d   = stat_q;
    if (accept_i) begin
      if (last_i) begin
        pos_d    = '0;
        hdr_ok_d = 1'b1;
        link_d   = '0;
        ulen_d   = '0;
        op_d     = '0;
        stat_d   = '0;
      end else begin
        pos_d    = len_next;
        hdr_ok_d = hdr_ok_next;
        link_d   = link_next;
        ulen_d   = ulen_next;
        op_d     = op_next;
        stat_d   = stat_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_ok_q <= 1'b1;
      link_q   <= '0;
      ulen_q   <= '0;
      op_q     <= '0;
      stat_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      hdr_ok_q <= hdr_ok_d;
      link_q   <= link_d;
      ulen_q   <= ulen_d;
      op_q     <= op_d;
      stat_q   <= stat_d;
    end
  end

  assign frame_o.hdr_ok    = hdr_ok_next;
  assign frame_o.link      = link_next;
  assign frame_o.udp_len   = ulen_next;
  assign frame_o.operation = op_next;
  assign frame_o.status    = stat_next;
  assign frame_o.len       = FRAME_LEN_W'(len_next);

endmodule

`default_nettype wire

// ===== hdl/udp_multicast_frame_classifier.sv =====
// Top level of the UDP multicast frame classifier: handshakes, verdict and result register.
//
//  Channel   | Direction | Transfer contents
//  ----------+-----------+---------------------------------------------------------
//  s_axis    | in        | one frame byte; tlast marks the final byte of the frame
//  m_axis    | out       | one verdict per frame; tuser = match flag, tdata = fields
//  cfg       | in        | register write: index 0 match_port, 1 group_prefix
//
//  A byte is taken every cycle at line rate. The verdict for a frame appears in the
//  result register on the cycle after its last byte is accepted. The input stalls only
//  while a verdict sits in the result register and the output side is not ready.
//  Reset clears the frame state and loads the register defaults (port 100, 224.224).
`default_nettype none

module udp_multicast_frame_classifier
  import umfc_pkg::*;
#(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input byte stream.
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  wire logic                 s_axis_tlast,   // last_byte
  // Verdict stream.
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [15:0] link_id, [26:16] payload_length, [34:27] operation_code,
  // [42:35] status_flag, [47:43] zero
  output      logic [47:0]          m_axis_tdata,
  output      logic                 m_axis_tuser,   // frame_match
  // Configuration writes.
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i
);

  logic        s_accept;
  logic        out_free;
  frame_t      cur;

  logic [15:0] match_port_q, group_prefix_q;

  logic        m_valid_q;
  logic        dev_q, dev_d;
  logic [15:0] link_q, link_d;
  logic [10:0] plen_q, plen_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  stat_q, stat_d;

  logic                   len_ok, ulen_ok, match;
  logic [15:0]            plen_raw;
  logic [FRAME_LEN_W-1:0] avail, plen;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q   <= MATCH_PORT_RST;
      group_prefix_q <= GROUP_PREFIX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MATCH_PORT:   match_port_q   <= cfg_data_i;
        CFG_GROUP_PREFIX: group_prefix_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The result register frees up in the same cycle its verdict is taken.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  umfc_frame_tracker #(
    .MaxFrame(MaxFrame)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (s_accept),
    .last_i        (s_axis_tlast),
    .byte_i        (s_axis_tdata),
    .match_port_i  (match_port_q),
    .group_prefix_i(group_prefix_q),
    .frame_o       (cur)
  );

  // Verdict. The frame view from the tracker already includes the current byte.
  // The payload length is clamped to what the frame actually carried past the
  // payload offset, then saturated to the field width.
  always_comb begin
    len_ok   = cur.len >= FRAME_LEN_W'(MIN_FRAME_LEN);
    ulen_ok  = cur.udp_len >= UDP_HDR_LEN;
    match    = cur.hdr_ok && len_ok && ulen_ok;
    plen_raw = cur.udp_len - UDP_HDR_LEN;
    avail    = cur.len - FRAME_LEN_W'(PAYLOAD_OFFSET);
    plen     = (plen_raw > 16'(avail)) ? avail : plen_raw[FRAME_LEN_W-1:0];

    dev_d  = match;
    link_d = '0;
    plen_d = '0;
    op_d   = '0;
    stat_d = '0;
    if (match) begin
      link_d = cur.link;
      plen_d = (plen > FRAME_LEN_W'(PAYLOAD_MAX)) ? PAYLOAD_MAX : plen[10:0];
      op_d   = cur.operation;
      stat_d = (plen > FRAME_LEN_W'(STATUS_OFFSET)) ? cur.status : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= s_accept && s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && s_axis_tlast) begin
      dev_q  <= dev_d;
      link_q <= link_d;
      plen_q <= plen_d;
      op_q   <= op_d;
      stat_q <= stat_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = dev_q;
  assign m_axis_tdata  = {5'd0, stat_q, op_q, plen_q, link_q};

  // A non-matching verdict carries nothing but zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("non-match verdict with nonzero fields");

  // The last byte of a frame always yields a verdict on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s_axis_tlast |=> m_axis_tvalid)
    else $error("verdict missing after last byte");

  // A byte inside a frame never produces a verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && !s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("verdict without last byte");

  // The status byte is reported only when the payload reaches past it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[26:16] <= 11'(STATUS_OFFSET))
      |-> m_axis_tdata[42:35] == 8'd0)
    else $error("status reported for short payload");

endmodule

`default_nettype wire
